// ===== hw/rtl/xml_entity_decoder_core_assert.svh =====
// Assertion macros shared by the XML entity decoder RTL.
// No dependencies; included by the modules that carry checks.
`ifndef XML_ENTITY_DECODER_CORE_ASSERT_SVH
`define XML_ENTITY_DECODER_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define XED_ASSERT_IMPL(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define XED_ASSERT_NEXT(lbl, ck, rn, ante, cons, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/xed_pkg.sv =====
// Package for the XML entity decoder: widths, character codes, entity tables
// and the structs passed between the decoder modules. No dependencies.
package xed_pkg;

    localparam int RUN_COUNT_BITS = 16;
    localparam int LEN_BITS       = 16;
    localparam int CMP_BITS       = ((RUN_COUNT_BITS > LEN_BITS) ? RUN_COUNT_BITS : LEN_BITS) + 1;
    localparam int HOLD_DEPTH     = 4;
    localparam int MAX_RESULTS    = 5;
    localparam int ENT_COUNT      = 3;
    localparam int ENT_MAX_LEN    = 5;

    typedef logic [7:0]                octet_t;
    typedef logic [RUN_COUNT_BITS-1:0] count_t;
    typedef logic [2:0]                num_t;

    localparam octet_t CH_AMP   = 8'h26;
    localparam octet_t CH_LT    = 8'h3C;
    localparam octet_t CH_GT    = 8'h3E;
    localparam octet_t CH_NL    = 8'h0A;
    localparam octet_t CH_SEMI  = 8'h3B;
    localparam octet_t TAG_RESET = CH_LT;

    // Spellings of the three entities, padded with zero.
    localparam octet_t ENT_TEXT [ENT_COUNT][ENT_MAX_LEN] = '{
        '{CH_AMP, 8'h6C, 8'h74, CH_SEMI, 8'h00},
        '{CH_AMP, 8'h67, 8'h74, CH_SEMI, 8'h00},
        '{CH_AMP, 8'h61, 8'h6D, 8'h70,   CH_SEMI}
    };
    localparam num_t   ENT_LEN  [ENT_COUNT] = '{3'd4, 3'd4, 3'd5};
    localparam octet_t ENT_CHAR [ENT_COUNT] = '{CH_LT, CH_GT, CH_AMP};

    typedef struct packed {
        octet_t              text_byte;
        logic [LEN_BITS-1:0] run_length;
        logic                last_byte;
    } item_t;

    typedef struct packed {
        octet_t data;
        logic   valid;
    } res_t;

    // All the results caused by one input item.
    typedef struct packed {
        res_t [MAX_RESULTS-1:0] res;
        num_t                   num;
        logic                   run_end;
    } bundle_t;

endpackage

// ===== hw/rtl/xed_step.sv =====
// Decoder step: entity hold state, output count and the combinational decode
// of one registered input byte into a result bundle. Depends on xed_pkg.
module xed_step
    import xed_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    advance,
    input  item_t   item,
    input  octet_t  tag_char,
    output bundle_t bundle
);

    octet_t [HOLD_DEPTH-1:0] held_reg, held_next;
    num_t                    hcount_reg, hcount_next;
    count_t                  emitted_reg, emitted_next;

    logic                    is_tag, run_stop, done, partial, flush, fresh;
    logic                    nl_keep, fresh_amp, fresh_emit, mid_emit;
    octet_t                  done_char, mid_byte;
    num_t                    c1, c3, total, k_idx;
    num_t                    hc_new;
    octet_t [HOLD_DEPTH-1:0] held_new;
    logic [RUN_COUNT_BITS:0] sum1, sum2;
    count_t                  cnt_mid, cnt_end;
    logic                    ok;

    always_comb
    begin
        is_tag   = (item.text_byte == tag_char);
        run_stop = is_tag || item.last_byte;

        // Match the held prefix plus this byte against every entity.
        done      = 1'b0;
        partial   = 1'b0;
        done_char = '0;
        for (int k = 0; k < ENT_COUNT; k++)
        begin
            ok = (hcount_reg < ENT_LEN[k]);
            for (int j = 0; j < HOLD_DEPTH; j++)
            begin
                if ((num_t'(j) < hcount_reg) && (held_reg[j] != ENT_TEXT[k][j]))
                begin
                    ok = 1'b0;
                end
            end
            if (ok && (item.text_byte == ENT_TEXT[k][hcount_reg]))
            begin
                if (hcount_reg + 3'd1 == ENT_LEN[k])
                begin
                    done      = 1'b1;
                    done_char = ENT_CHAR[k];
                end
                else
                begin
                    partial = 1'b1;
                end
            end
        end

        if (is_tag)
        begin
            flush = (hcount_reg != '0);
        end
        else
        begin
            flush = (hcount_reg != '0) && !done && !partial;
        end
        c1 = flush ? hcount_reg : '0;

        sum1    = {1'b0, emitted_reg} + (RUN_COUNT_BITS + 1)'(c1);
        cnt_mid = sum1[RUN_COUNT_BITS] ? '1 : sum1[RUN_COUNT_BITS-1:0];

        fresh      = !is_tag && ((hcount_reg == '0) || flush);
        nl_keep    = (cnt_mid != '0) &&
                     ((CMP_BITS'(cnt_mid) + CMP_BITS'(1)) < CMP_BITS'(item.run_length));
        fresh_amp  = fresh && (item.text_byte == CH_AMP);
        fresh_emit = fresh && (item.text_byte != CH_AMP) &&
                     ((item.text_byte != CH_NL) || nl_keep);
        mid_emit   = (!is_tag && done) || fresh_emit;
        mid_byte   = done ? done_char : item.text_byte;

        held_new = held_reg;
        hc_new   = '0;
        if (!is_tag && !done)
        begin
            if (partial)
            begin
                held_new[hcount_reg[1:0]] = item.text_byte;
                hc_new                    = hcount_reg + 3'd1;
            end
            else if (fresh_amp)
            begin
                held_new[0] = CH_AMP;
                hc_new      = 3'd1;
            end
        end

        // At the end of a run the bytes still held go out unchanged.
        c3    = run_stop ? hc_new : '0;
        total = c1 + num_t'(mid_emit) + c3;

        for (int i = 0; i < MAX_RESULTS; i++)
        begin
            k_idx = num_t'(i) - c1 - num_t'(mid_emit);
            if (num_t'(i) < c1)
            begin
                bundle.res[i] = '{data: held_reg[i % HOLD_DEPTH], valid: 1'b1};
            end
            else if ((num_t'(i) == c1) && mid_emit)
            begin
                bundle.res[i] = '{data: mid_byte, valid: 1'b1};
            end
            else
            begin
                bundle.res[i] = '{data: held_new[k_idx[1:0]], valid: 1'b1};
            end
        end

        bundle.run_end = run_stop;
        bundle.num     = total;
        if (run_stop && (total == '0))
        begin
            // Empty end marker.
            bundle.res[0] = '{data: '0, valid: 1'b0};
            bundle.num    = 3'd1;
        end

        sum2    = {1'b0, cnt_mid} + (RUN_COUNT_BITS + 1)'(mid_emit);
        cnt_end = sum2[RUN_COUNT_BITS] ? '1 : sum2[RUN_COUNT_BITS-1:0];

        held_next    = held_reg;
        hcount_next  = hcount_reg;
        emitted_next = emitted_reg;
        if (advance)
        begin
            held_next    = held_new;
            hcount_next  = run_stop ? '0 : hc_new;
            emitted_next = run_stop ? '0 : cnt_end;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg    <= '0;
            hcount_reg  <= '0;
            emitted_reg <= '0;
        end
        else
        begin
            held_reg    <= held_next;
            hcount_reg  <= hcount_next;
            emitted_reg <= emitted_next;
        end
    end

endmodule

// ===== hw/rtl/xed_out_buf.sv =====
// Result register of the decoder: holds one bundle and hands its results out
// one beat at a time. Depends on xed_pkg and the assertion macro header.
`include "xml_entity_decoder_core_assert.svh"

module xed_out_buf
    import xed_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    load,
    input  bundle_t bundle,
    output logic    free,
    output logic    out_valid,
    input  logic    out_stall,
    output octet_t  out_byte,
    output logic    byte_valid,
    output logic    run_end
);

    bundle_t bundle_reg, bundle_next;
    logic    vld_reg, vld_next;
    num_t    idx_reg, idx_next;
    logic    last_idx, drain_done;
    res_t    cur;

    always_comb
    begin
        last_idx   = (idx_reg == bundle_reg.num - 3'd1);
        drain_done = vld_reg && !out_stall && last_idx;
        free       = !vld_reg || drain_done;

        bundle_next = bundle_reg;
        vld_next    = vld_reg;
        idx_next    = idx_reg;
        if (load)
        begin
            bundle_next = bundle;
            vld_next    = 1'b1;
            idx_next    = '0;
        end
        else if (drain_done)
        begin
            vld_next = 1'b0;
        end
        else if (vld_reg && !out_stall)
        begin
            idx_next = idx_reg + 3'd1;
        end
    end

    always_comb
    begin
        cur        = bundle_reg.res[idx_reg];
        out_valid  = vld_reg;
        out_byte   = cur.data;
        byte_valid = cur.valid;
        run_end    = bundle_reg.run_end && last_idx;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
            idx_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
            idx_reg <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bundle_reg <= bundle_next;
    end

    `XED_ASSERT_IMPL(a_idx_in_range, clk, rst_n, vld_reg,
        (bundle_reg.num != '0) && (idx_reg < bundle_reg.num),
        "result index outside the held bundle")
    `XED_ASSERT_IMPL(a_end_on_last, clk, rst_n, vld_reg && run_end, last_idx,
        "run end flagged before the last result")
    `XED_ASSERT_IMPL(a_marker_form, clk, rst_n, vld_reg && !byte_valid,
        run_end && (out_byte == '0), "empty result that is not a clean end marker")
    `XED_ASSERT_NEXT(a_hold_on_stall, clk, rst_n, vld_reg && out_stall && !load,
        vld_reg && $stable(idx_reg), "result sequence moved while stalled")

endmodule

// ===== hw/rtl/xml_entity_decoder_core.sv =====
// Top level of the XML entity decoder: delimiter register, input register,
// decode step and result register. Depends on xed_pkg, xed_step, xed_out_buf.
//
// The core takes the raw bytes of a text run, one beat per byte, and returns
// the decoded text one byte per output beat. The entities &lt;, &gt; and &amp;
// become <, > and &; every other byte passes through. Up to four bytes of a
// possible entity are held back and come out unchanged if the match fails.
// A newline is dropped when it would be the first byte out of the run or when
// the output count has reached run_length minus one. A byte equal to the
// delimiter register (reset value '<') ends the run and is not returned; a
// byte flagged last_byte also ends it and is decoded normally. The final beat
// of a run carries run_end; if the run produced nothing it is an empty marker
// with byte_valid low and out_byte zero. Each input byte goes through an input
// register, combinational decode logic and a five-entry result register. The
// core takes one byte per cycle as long as each byte gives at most one result
// and out_stall stays low; a byte that gives k results (a flush of held bytes
// at a failed match or at the end of a run) keeps the result register busy
// until all k are out, and the input stalls meanwhile. A byte that gives no
// result (held, or a dropped newline) still passes through the input register.
// The delimiter register is written through cfg_wr_en and cfg_wr_data
// and should only be changed while no beat is in flight.
module xml_entity_decoder_core
    import xed_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_wr_en,
    input  octet_t              cfg_wr_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  octet_t              text_byte,
    input  logic [LEN_BITS-1:0] run_length,
    input  logic                last_byte,
    output logic                out_valid,
    input  logic                out_stall,
    output octet_t              out_byte,
    output logic                byte_valid,
    output logic                run_end
);

    octet_t  tag_reg, tag_next;
    logic    in_vld_reg, in_vld_next;
    item_t   item_reg, item_next;
    logic    buf_free, advance, load, accept;
    bundle_t bundle;

    // The registered byte moves into the decode step whenever the result
    // register can take its bundle this cycle.
    always_comb
    begin
        advance  = in_vld_reg && buf_free;
        load     = advance && (bundle.num != '0);
        in_stall = in_vld_reg && !buf_free;
        accept   = in_valid && !in_stall;

        tag_next = cfg_wr_en ? cfg_wr_data : tag_reg;

        item_next   = item_reg;
        in_vld_next = in_vld_reg;
        if (accept)
        begin
            item_next   = '{text_byte: text_byte, run_length: run_length, last_byte: last_byte};
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg    <= TAG_RESET;
            in_vld_reg <= 1'b0;
        end
        else
        begin
            tag_reg    <= tag_next;
            in_vld_reg <= in_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    xed_step u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .item     (item_reg),
        .tag_char (tag_reg),
        .bundle   (bundle)
    );

    xed_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .bundle     (bundle),
        .free       (buf_free),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_end    (run_end)
    );

endmodule
